// ----- rtl/epsp_pkg.sv -----
// Shared types, constants and the arctangent table of the stereo panner.
`default_nettype none
package epsp_pkg;

  localparam int BUFFER_FRAMES = 512;
  localparam int CORDIC_STEPS = 24;
  localparam int ROT_W = 41;
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [32:0] ANG_HALF_PI = 33'sd1073741824;
  localparam logic [31:0] ANG_PI = 32'h8000_0000;
  localparam logic [15:0] Q15_ONE = 16'd32768;

  typedef enum logic {
    CFG_PAN_ENABLE    = 1'b0,
    CFG_SPEAKER_COUNT = 1'b1
  } cfg_index_t;

  // Everything that rides along with an item while the angle work runs.
  typedef struct packed {
    logic               valid;
    logic [8:0]         frame;
    logic               pan;
    logic signed [23:0] base_l;
    logic signed [23:0] base_r;
    logic signed [23:0] sample;
  } side_t;

  // Arctangent of 2^-step, in units where pi is 2^31.
  function automatic logic [29:0] atan_angle(input int step);
    logic [29:0] v;
    case (step)
      0:  v = 30'h20000000;
      1:  v = 30'h12E4051D;
      2:  v = 30'h09FB385B;
      3:  v = 30'h051111D4;
      4:  v = 30'h028B0D43;
      5:  v = 30'h0145D7E1;
      6:  v = 30'h00A2F61E;
      7:  v = 30'h00517C55;
      8:  v = 30'h0028BE53;
      9:  v = 30'h00145F2E;
      10: v = 30'h000A2F98;
      11: v = 30'h000517CC;
      12: v = 30'h00028BE6;
      13: v = 30'h000145F3;
      14: v = 30'h0000A2F9;
      15: v = 30'h0000517C;
      16: v = 30'h000028BE;
      17: v = 30'h0000145F;
      18: v = 30'h00000A2F;
      19: v = 30'h00000517;
      20: v = 30'h0000028B;
      21: v = 30'h00000145;
      22: v = 30'h000000A2;
      23: v = 30'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/epsp_if.sv -----
// Valid/ready channel interfaces for the panner input items and results.
`default_nettype none
interface epsp_in_if;
  logic               valid;
  logic               ready;
  logic [8:0]         frame_index;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [17:0] quat_w;
  logic signed [17:0] quat_x;
  logic signed [17:0] quat_y;
  logic signed [17:0] quat_z;
  logic signed [23:0] sample_in;
  logic signed [23:0] mix_left_in;
  logic signed [23:0] mix_right_in;

  modport source (output valid, frame_index, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y,
                  quat_z, sample_in, mix_left_in, mix_right_in, input ready);
  modport sink (input valid, frame_index, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y,
                quat_z, sample_in, mix_left_in, mix_right_in, output ready);
endinterface

interface epsp_out_if;
  logic               valid;
  logic               ready;
  logic [8:0]         frame_out;
  logic signed [23:0] mix_left_out;
  logic signed [23:0] mix_right_out;

  modport source (output valid, frame_out, mix_left_out, mix_right_out, input ready);
  modport sink (input valid, frame_out, mix_left_out, mix_right_out, output ready);
endinterface
`default_nettype wire

// ----- rtl/equal_power_stereo_panner_unit.sv -----
// Equal-power stereo panner: rotation, azimuth, gains and saturating mix.
// An item passes the quaternion rotation, normalization and the 24-step vectoring
// CORDIC, the 24-step rotation CORDIC with gain rounding, and the mix multiply and
// add on its way from input transfer to result.
// Throughput is one item per cycle; the whole pipeline holds while a result waits.
// Synchronous reset empties the pipeline and sets pan_enable to 1, speaker_count to 2.
`default_nettype none
module equal_power_stereo_panner_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [1:0] cfg_data,
  epsp_in_if.sink    in_ch,
  epsp_out_if.source out_ch
);

  localparam int RW = epsp_pkg::ROT_W;

  logic       pan_enable;
  logic [1:0] speaker_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      pan_enable    <= 1'b1;
      speaker_count <= 2'd2;
    end else if (cfg_we) begin
      case (epsp_pkg::cfg_index_t'(cfg_index))
        epsp_pkg::CFG_PAN_ENABLE:    pan_enable    <= cfg_data[0];
        epsp_pkg::CFG_SPEAKER_COUNT: speaker_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together unless a result is stuck at the output.
  logic en;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  logic            in_range, pan;
  epsp_pkg::side_t side0;

  always_comb begin
    in_range     = ({8'b0, in_ch.frame_index} < 17'(epsp_pkg::BUFFER_FRAMES));
    pan          = in_range && pan_enable && (speaker_count == 2'd2);
    side0.valid  = in_ch.valid;
    side0.frame  = in_ch.frame_index;
    side0.pan    = pan;
    side0.sample = in_ch.sample_in;
    side0.base_l = (in_range && !pan && speaker_count >= 2'd1) ?
                   in_ch.sample_in : in_ch.mix_left_in;
    side0.base_r = (in_range && !pan && speaker_count >= 2'd2) ?
                   in_ch.sample_in : in_ch.mix_right_in;
  end

  // Stage 1: cross products of the vector part with the position.
  epsp_pkg::side_t    sd1;
  logic signed [49:0] m_qypz, m_qzpy, m_qzpx, m_qxpz, m_qxpy, m_qypx;
  logic signed [17:0] qw1, qx1, qy1, qz1;
  logic signed [31:0] px1, pz1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sd1.valid <= 1'b0;
    end else if (en) begin
      sd1    <= side0;
      m_qypz <= in_ch.quat_y * in_ch.pos_z;
      m_qzpy <= in_ch.quat_z * in_ch.pos_y;
      m_qzpx <= in_ch.quat_z * in_ch.pos_x;
      m_qxpz <= in_ch.quat_x * in_ch.pos_z;
      m_qxpy <= in_ch.quat_x * in_ch.pos_y;
      m_qypx <= in_ch.quat_y * in_ch.pos_x;
      qw1 <= in_ch.quat_w;
      qx1 <= in_ch.quat_x;
      qy1 <= in_ch.quat_y;
      qz1 <= in_ch.quat_z;
      px1 <= in_ch.pos_x;
      pz1 <= in_ch.pos_z;
    end
  end

  // Stage 2: t = 2 * floor(cross / 2^16).
  logic signed [50:0] d_x, d_y, d_z;
  assign d_x = 51'(m_qypz) - 51'(m_qzpy);
  assign d_y = 51'(m_qzpx) - 51'(m_qxpz);
  assign d_z = 51'(m_qxpy) - 51'(m_qypx);

  epsp_pkg::side_t    sd2;
  logic signed [35:0] tx2, ty2, tz2;
  logic signed [17:0] qw2, qx2, qy2, qz2;
  logic signed [31:0] px2, pz2;

  always_ff @(posedge clk) begin
    if (rst) begin
      sd2.valid <= 1'b0;
    end else if (en) begin
      sd2 <= sd1;
      tx2 <= $signed({d_x[50:16], 1'b0});
      ty2 <= $signed({d_y[50:16], 1'b0});
      tz2 <= $signed({d_z[50:16], 1'b0});
      qw2 <= qw1;
      qx2 <= qx1;
      qy2 <= qy1;
      qz2 <= qz1;
      px2 <= px1;
      pz2 <= pz1;
    end
  end

  // Stage 3: second set of products.
  epsp_pkg::side_t    sd3;
  logic signed [53:0] n_qwtx, n_qytz, n_qzty, n_qwtz, n_qxty, n_qytx;
  logic signed [31:0] px3, pz3;

  always_ff @(posedge clk) begin
    if (rst) begin
      sd3.valid <= 1'b0;
    end else if (en) begin
      sd3    <= sd2;
      n_qwtx <= qw2 * tx2;
      n_qytz <= qy2 * tz2;
      n_qzty <= qz2 * ty2;
      n_qwtz <= qw2 * tz2;
      n_qxty <= qx2 * ty2;
      n_qytx <= qy2 * tx2;
      px3 <= px2;
      pz3 <= pz2;
    end
  end

  // Stage 4: rotated x and z.
  logic signed [55:0] s_x, s_z;
  assign s_x = 56'(n_qwtx) + 56'(n_qytz) - 56'(n_qzty);
  assign s_z = 56'(n_qwtz) + 56'(n_qxty) - 56'(n_qytx);

  epsp_pkg::side_t    sd4;
  logic signed [RW-1:0] rx4, rz4;

  always_ff @(posedge clk) begin
    if (rst) begin
      sd4.valid <= 1'b0;
    end else if (en) begin
      sd4 <= sd3;
      rx4 <= RW'(px3) + RW'($signed(s_x[55:16]));
      rz4 <= RW'(pz3) + RW'($signed(s_z[55:16]));
    end
  end

  logic [30:0]     half_ang;
  epsp_pkg::side_t sd_v;

  epsp_vec u_vec (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .rx       (rx4),
    .rz       (rz4),
    .side_in  (sd4),
    .half_ang (half_ang),
    .side_out (sd_v)
  );

  logic [15:0]     gain_l, gain_r;
  epsp_pkg::side_t sd_r;

  epsp_rot u_rot (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .half_ang (half_ang),
    .side_in  (sd_v),
    .gain_l   (gain_l),
    .gain_r   (gain_r),
    .side_out (sd_r)
  );

  // Mix stage 1: gain times sample.
  epsp_pkg::side_t    sd_m;
  logic signed [40:0] prod_l, prod_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      sd_m.valid <= 1'b0;
    end else if (en) begin
      sd_m   <= sd_r;
      prod_l <= $signed({1'b0, gain_l}) * sd_r.sample;
      prod_r <= $signed({1'b0, gain_r}) * sd_r.sample;
    end
  end

  // Mix stage 2: round, add and saturate into the output register.
  function automatic logic signed [23:0] mix_sat(input logic signed [23:0] base,
                                                  input logic signed [40:0] prod);
    logic signed [40:0] r;
    logic signed [27:0] s;
    r = prod + 41'sd16384;
    s = 28'(base) + 28'($signed(r[40:15]));
    if (s > 28'sd8388607) begin
      return 24'sd8388607;
    end else if (s < -28'sd8388608) begin
      return -24'sd8388608;
    end
    return s[23:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (en) begin
      out_ch.valid         <= sd_m.valid;
      out_ch.frame_out     <= sd_m.frame;
      out_ch.mix_left_out  <= sd_m.pan ? mix_sat(sd_m.base_l, prod_l) : sd_m.base_l;
      out_ch.mix_right_out <= sd_m.pan ? mix_sat(sd_m.base_r, prod_r) : sd_m.base_r;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_ch.valid)
    else $error("result valid right after reset");

  a_half_angle: assert property (@(posedge clk) disable iff (rst)
    sd_v.valid |-> (half_ang <= 31'h4000_0000))
    else $error("half angle above a quarter turn");

  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    sd_r.valid |-> (gain_l <= epsp_pkg::Q15_ONE && gain_r <= epsp_pkg::Q15_ONE))
    else $error("pan gain above unity");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (sd_m.valid && !en) |=> (sd_m.valid && $stable(sd_m.frame)))
    else $error("mix stage changed while stalled");

endmodule
`default_nettype wire

// ----- rtl/epsp_vec.sv -----
// Azimuth pipeline: magnitude, normalization, CORDIC vectoring and half angle.
`default_nettype none
module epsp_vec (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic signed [epsp_pkg::ROT_W-1:0]   rx,
  input  logic signed [epsp_pkg::ROT_W-1:0]   rz,
  input  epsp_pkg::side_t                     side_in,
  output logic [30:0]                         half_ang,
  output epsp_pkg::side_t                     side_out
);

  localparam int RW = epsp_pkg::ROT_W;
  localparam int N = epsp_pkg::CORDIC_STEPS;

  // Stage A: magnitudes.
  logic [RW-1:0]   ax_a, az_a, m_a;
  logic            neg_a;
  epsp_pkg::side_t sd_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      sd_a.valid <= 1'b0;
    end else if (en) begin
      sd_a  <= side_in;
      neg_a <= rx[RW-1];
      ax_a  <= rx[RW-1] ? RW'(-rx) : RW'(rx);
      az_a  <= rz[RW-1] ? RW'(-rz) : RW'(rz);
      m_a   <= ((rx[RW-1] ? RW'(-rx) : RW'(rx)) > (rz[RW-1] ? RW'(-rz) : RW'(rz))) ?
               (rx[RW-1] ? RW'(-rx) : RW'(rx)) : (rz[RW-1] ? RW'(-rz) : RW'(rz));
    end
  end

  // Stage B: leading one of the larger magnitude.
  logic [5:0]      msb_next;
  logic [5:0]      msb_b;
  logic [RW-1:0]   ax_b, az_b;
  logic            neg_b, zero_b;
  epsp_pkg::side_t sd_b;

  always_comb begin
    msb_next = '0;
    for (int k = 0; k < RW; k++) begin
      if (m_a[k]) begin
        msb_next = 6'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sd_b.valid <= 1'b0;
    end else if (en) begin
      sd_b   <= sd_a;
      ax_b   <= ax_a;
      az_b   <= az_a;
      neg_b  <= neg_a;
      zero_b <= (m_a == '0);
      msb_b  <= msb_next;
    end
  end

  // Stage C: bring the larger magnitude into [2^29, 2^30).
  logic [RW-1:0] ax_sh, az_sh;

  always_comb begin
    if (msb_b >= 6'd30) begin
      ax_sh = ax_b >> (msb_b - 6'd29);
      az_sh = az_b >> (msb_b - 6'd29);
    end else begin
      ax_sh = ax_b << (6'd29 - msb_b);
      az_sh = az_b << (6'd29 - msb_b);
    end
  end

  logic signed [32:0] cx [0:N];
  logic signed [32:0] cy [0:N];
  logic signed [32:0] ca [0:N];
  logic               cneg [0:N];
  logic               czero [0:N];
  epsp_pkg::side_t    csd [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      csd[0].valid <= 1'b0;
    end else if (en) begin
      csd[0]   <= sd_b;
      cx[0]    <= $signed({2'b00, ax_sh[30:0]});
      cy[0]    <= $signed({2'b00, az_sh[30:0]});
      ca[0]    <= '0;
      cneg[0]  <= neg_b;
      czero[0] <= zero_b;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic signed [32:0] ATAN_I = $signed({3'b000, epsp_pkg::atan_angle(i)});
    always_ff @(posedge clk) begin
      if (rst) begin
        csd[i+1].valid <= 1'b0;
      end else if (en) begin
        csd[i+1]   <= csd[i];
        cneg[i+1]  <= cneg[i];
        czero[i+1] <= czero[i];
        if (!cy[i][32]) begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          ca[i+1] <= ca[i] + ATAN_I;
        end else begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          ca[i+1] <= ca[i] - ATAN_I;
        end
      end
    end
  end

  // Final stage: clamp, fold by the sign of x and halve.
  logic [31:0] phi, ang;

  always_comb begin
    if (czero[N] || ca[N][32]) begin
      phi = '0;
    end else if (ca[N] > epsp_pkg::ANG_HALF_PI) begin
      phi = 32'(epsp_pkg::ANG_HALF_PI);
    end else begin
      phi = ca[N][31:0];
    end
    ang = cneg[N] ? (epsp_pkg::ANG_PI - phi) : phi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else if (en) begin
      side_out <= csd[N];
      half_ang <= ang[31:1];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/epsp_rot.sv -----
// Gain pipeline: CORDIC rotation of the half angle and rounding to Q1.15.
`default_nettype none
module epsp_rot (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic [30:0]     half_ang,
  input  epsp_pkg::side_t side_in,
  output logic [15:0]     gain_l,
  output logic [15:0]     gain_r,
  output epsp_pkg::side_t side_out
);

  localparam int N = epsp_pkg::CORDIC_STEPS;

  logic signed [32:0] cx [0:N];
  logic signed [32:0] cy [0:N];
  logic signed [32:0] cz [0:N];
  epsp_pkg::side_t    csd [0:N];

  assign cx[0]  = epsp_pkg::CORDIC_GAIN;
  assign cy[0]  = '0;
  assign cz[0]  = $signed({2'b00, half_ang});
  assign csd[0] = side_in;

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic signed [32:0] ATAN_I = $signed({3'b000, epsp_pkg::atan_angle(i)});
    always_ff @(posedge clk) begin
      if (rst) begin
        csd[i+1].valid <= 1'b0;
      end else if (en) begin
        csd[i+1] <= csd[i];
        if (!cz[i][32]) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - ATAN_I;
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + ATAN_I;
        end
      end
    end
  end

  function automatic logic [15:0] to_q15(input logic signed [32:0] v);
    logic [31:0] c;
    if (v[32]) begin
      c = '0;
    end else if (v > epsp_pkg::ANG_HALF_PI) begin
      c = 32'(epsp_pkg::ANG_HALF_PI);
    end else begin
      c = v[31:0];
    end
    c = c + 32'd16384;
    return c[30:15];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else if (en) begin
      side_out <= csd[N];
      gain_l   <= to_q15(cy[N]);
      gain_r   <= to_q15(cx[N]);
    end
  end

endmodule
`default_nettype wire
